/* src/ste_pkg.sv */
`default_nettype none
package ste_pkg;

  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int NAME_BYTES_DEF   = 19;
  localparam int NAME_FIELD_BYTES = 19;
  localparam int NAME_W           = 8 * NAME_FIELD_BYTES;
  localparam int VALUE_W          = 32;
  localparam int KIND_W           = 2;
  localparam int CMD_W            = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_PURGE  = 2'd3
  } cmd_t;

  localparam logic [KIND_W-1:0] KIND_MACRO = 2'd0;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [63:0]               name_low;
    logic [63:0]               name_mid;
    logic [23:0]               name_high;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_PURGE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

/* src/ste_in_if.sv */
`default_nettype none
interface ste_in_if;
  logic                               valid;
  logic                               ready;
  logic [ste_pkg::CMD_W-1:0]          command;
  logic [63:0]                        name_part0;
  logic [63:0]                        name_part1;
  logic [23:0]                        name_part2;
  logic [ste_pkg::KIND_W-1:0]         entry_kind;
  logic signed [ste_pkg::VALUE_W-1:0] value_in;

  modport source (
    output valid, command, name_part0, name_part1, name_part2, entry_kind, value_in,
    input  ready
  );

  modport sink (
    input  valid, command, name_part0, name_part1, name_part2, entry_kind, value_in,
    output ready
  );
endinterface
`default_nettype wire

/* src/ste_out_if.sv */
`default_nettype none
interface ste_out_if #(
  parameter int CNT_W = $clog2(ste_pkg::TABLE_DEPTH_DEF + 1)
);
  logic                               valid;
  logic                               ready;
  logic                               found;
  logic signed [ste_pkg::VALUE_W-1:0] value_out;
  logic [CNT_W-1:0]                   item_count;
  logic [CNT_W-1:0]                   removed_count;
  logic                               status;

  modport source (
    output valid, found, value_out, item_count, removed_count, status,
    input  ready
  );

  modport sink (
    input  valid, found, value_out, item_count, removed_count, status,
    output ready
  );
endinterface
`default_nettype wire

/* src/ste_ram.sv */
`default_nettype none
module ste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/symbol_table_engine.sv */
`default_nettype none
// Flow: clear and append are done in ST_EXEC and then pass to ST_DONE; search and purge
// then walk the table, one table entry read from the RAM per cycle, before ST_DONE.
// Throughput: one transaction at a time; the next one is taken once the result enters the
// output register, which holds it until the sink takes it.
// Reset: synchronous, clears the entry count and control state; the table RAM is not
// cleared, and entries beyond the count are never read.
module symbol_table_engine #(
  parameter int TABLE_DEPTH = ste_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_BYTES  = ste_pkg::NAME_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  ste_in_if.sink     req,
  ste_out_if.source  rsp
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EW = $bits(ste_pkg::entry_t);

  ste_pkg::state_t state, state_next;
  ste_pkg::cmd_t   cmd;

  logic [ste_pkg::NAME_W-1:0]         raw_name, norm_name, key_name;
  logic                               keep;
  logic [ste_pkg::KIND_W-1:0]         key_kind;
  logic signed [ste_pkg::VALUE_W-1:0] key_value;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  logic          data_valid, data_valid_next;
  logic          data_last, data_last_next;
  logic          issue;
  logic          hit;

  logic                               res_found, res_found_next;
  logic signed [ste_pkg::VALUE_W-1:0] res_value, res_value_next;
  logic [CW-1:0]                      res_removed, res_removed_next;
  logic                               res_status, res_status_next;

  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  ste_pkg::entry_t ram_wr_data;
  logic            ram_rd_en;
  logic [EW-1:0]   ram_rd_raw;
  ste_pkg::entry_t rd_entry;

  logic accept;
  logic load_out;

  assign req.ready = (state == ste_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    raw_name = {req.name_part2, req.name_part1, req.name_part0};
    keep     = 1'b1;
    for (int i = 0; i < ste_pkg::NAME_FIELD_BYTES; i++) begin
      keep = keep && (raw_name[8*i +: 8] != 8'd0) && (i < NAME_BYTES);
      norm_name[8*i +: 8] = keep ? raw_name[8*i +: 8] : 8'd0;
    end
  end

  ste_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (ram_rd_raw)
  );

  assign rd_entry = ste_pkg::entry_t'(ram_rd_raw);
  assign hit      = ({rd_entry.name_high, rd_entry.name_mid, rd_entry.name_low} == key_name);
  assign issue    = (rd_ptr < count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ste_pkg::ST_IDLE;
      count      <= '0;
      data_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      data_valid <= data_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= ste_pkg::cmd_t'(req.command);
      key_name  <= norm_name;
      key_kind  <= req.entry_kind;
      key_value <= req.value_in;
    end
    rd_ptr      <= rd_ptr_next;
    wr_ptr      <= wr_ptr_next;
    data_last   <= data_last_next;
    res_found   <= res_found_next;
    res_value   <= res_value_next;
    res_removed <= res_removed_next;
    res_status  <= res_status_next;
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    rd_ptr_next      = rd_ptr;
    wr_ptr_next      = wr_ptr;
    data_valid_next  = 1'b0;
    data_last_next   = 1'b0;
    res_found_next   = res_found;
    res_value_next   = res_value;
    res_removed_next = res_removed;
    res_status_next  = res_status;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = wr_ptr[AW-1:0];
    ram_wr_data      = rd_entry;
    ram_rd_en        = 1'b0;
    load_out         = 1'b0;

    case (state)
      ste_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = ste_pkg::ST_EXEC;
        end
      end

      ste_pkg::ST_EXEC: begin
        res_found_next   = 1'b0;
        res_value_next   = '0;
        res_removed_next = '0;
        res_status_next  = ste_pkg::STATUS_OK;
        rd_ptr_next      = '0;
        wr_ptr_next      = '0;
        state_next       = ste_pkg::ST_DONE;
        case (cmd)
          ste_pkg::CMD_CLEAR: begin
            count_next = '0;
          end
          ste_pkg::CMD_APPEND: begin
            if (count >= CW'(TABLE_DEPTH)) begin
              res_status_next = ste_pkg::STATUS_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = count[AW-1:0];
              ram_wr_data = '{name_low:  key_name[63:0],
                              name_mid:  key_name[127:64],
                              name_high: key_name[151:128],
                              kind:      key_kind,
                              value:     key_value};
              count_next  = count + CW'(1);
            end
          end
          ste_pkg::CMD_SEARCH: begin
            if (count != '0) begin
              state_next = ste_pkg::ST_SEARCH;
            end
          end
          ste_pkg::CMD_PURGE: begin
            if (count != '0) begin
              state_next = ste_pkg::ST_PURGE;
            end
          end
          default: begin
            state_next = ste_pkg::ST_DONE;
          end
        endcase
      end

      ste_pkg::ST_SEARCH: begin
        if (issue) begin
          ram_rd_en       = 1'b1;
          rd_ptr_next     = rd_ptr + CW'(1);
          data_valid_next = 1'b1;
          data_last_next  = ((rd_ptr + CW'(1)) == count);
        end
        if (data_valid) begin
          if (hit) begin
            res_found_next  = 1'b1;
            res_value_next  = rd_entry.value;
            data_valid_next = 1'b0;
            state_next      = ste_pkg::ST_DONE;
          end else if (data_last) begin
            state_next = ste_pkg::ST_DONE;
          end
        end
      end

      ste_pkg::ST_PURGE: begin
        if (issue) begin
          ram_rd_en       = 1'b1;
          rd_ptr_next     = rd_ptr + CW'(1);
          data_valid_next = 1'b1;
          data_last_next  = ((rd_ptr + CW'(1)) == count);
        end
        if (data_valid) begin
          if (rd_entry.kind == ste_pkg::KIND_MACRO) begin
            res_removed_next = res_removed + CW'(1);
          end else begin
            ram_wr_en   = 1'b1;
            wr_ptr_next = wr_ptr + CW'(1);
          end
          if (data_last) begin
            count_next = wr_ptr_next;
            state_next = ste_pkg::ST_DONE;
          end
        end
      end

      ste_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ste_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ste_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.found         <= res_found;
      rsp.value_out     <= res_value;
      rsp.item_count    <= count;
      rsp.removed_count <= res_removed;
      rsp.status        <= res_status;
    end
  end

endmodule
`default_nettype wire
